>>> src/stream_dedup_first_occurrence_assert.svh
// Assertion macros used by the stream de-duplication RTL.
`ifndef STREAM_DEDUP_FIRST_OCCURRENCE_ASSERT_SVH
`define STREAM_DEDUP_FIRST_OCCURRENCE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define SDF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define SDF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sdf_pkg.sv
package sdf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int UCOUNT_W    = 9;
   localparam int VALUE_W     = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic                      kept;
      logic [UCOUNT_W-1:0]       unique_count;
      logic                      end_of_array;
      logic                      overflow;
   } rsp_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   typedef enum logic [0:0] {
      BACK_IDLE,
      BACK_SEARCH
   } back_state_type;

endpackage

>>> src/stream_dedup_first_occurrence.sv
// Channel   Ports                        Handshake
// input     start, busy, req_data        beat taken when start is high and busy is low
// result    rsp_strobe, rsp_data         beat valid for the one cycle rsp_strobe is high
//
// The search engine reads kept values in order until it hits the item's duplicate or,
// when the item is new, has read every kept value; the bound is the single read port
// of the seen-value table, one entry per cycle. The result is registered and shows in
// the cycle after the search ends. A two-beat queue lets the sender run ahead of the
// search.
// Reset clears the queue, the engine and the kept count; the table itself is not cleared.
// The receiver cannot stall, so results never wait.
module stream_dedup_first_occurrence import sdf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   queue_head_type head;
   logic           pop;

   sdf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .head     (head),
      .pop      (pop)
   );

   sdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> src/sdf_front.sv
module sdf_front import sdf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  req_type        req_data,
   output queue_head_type head,
   input  logic           pop
);

   req_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;
   logic              push;
   logic              pop_ok;

   assign busy   = (level_ff == QLVL_W'(QUEUE_DEPTH));
   assign push   = start && !busy;
   assign pop_ok = pop && (level_ff != '0);

   assign head.valid = (level_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop_ok) begin
         level_in = level_ff + 1'b1;
      end else if (pop_ok && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

>>> src/sdf_back.sv
`include "stream_dedup_first_occurrence_assert.svh"

module sdf_back import sdf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_strobe,
   output rsp_type        rsp_data
);

   back_state_type     state_ff, state_in;
   req_type            item_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [VALUE_W-1:0] mem_ff [TABLE_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               searching;
   logic               hit;
   logic               finish;
   logic               rd_en;
   logic               room;
   logic               wr_en;
   logic [CNT_W-1:0]   count_next;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               state_in = BACK_SEARCH;
            end
         end
         BACK_SEARCH: begin
            if (finish) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // The search reads one kept entry a cycle; a read's data is registered and compared
   // in the next cycle, so the scan ends on a hit or once every entry has been seen.
   always_comb begin
      searching  = (state_ff == BACK_SEARCH);
      pop        = (state_ff == BACK_IDLE) && head.valid;
      hit        = pend_ff && (rd_data_ff == item_ff.value);
      finish     = searching && (hit || (idx_ff == count_ff));
      rd_en      = searching && (idx_ff != count_ff);
      room       = (count_ff < CNT_W'(TABLE_DEPTH));
      wr_en      = finish && !hit && room;
      count_next = count_ff + CNT_W'(wr_en);

      idx_in  = pop ? '0 : (rd_en ? idx_ff + 1'b1 : idx_ff);
      pend_in = rd_en;

      count_in = count_ff;
      if (finish) begin
         count_in = item_ff.is_last ? '0 : count_next;
      end

      rsp_in.value_out    = item_ff.value;
      rsp_in.kept         = wr_en;
      rsp_in.unique_count = UCOUNT_W'(count_next);
      rsp_in.end_of_array = item_ff.is_last;
      rsp_in.overflow     = finish && !hit && !room;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (pop) begin
         item_ff <= head.item;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[count_ff[IDX_W-1:0]] <= item_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `SDF_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_DEPTH),
               "kept count beyond table depth")
   `SDF_ASSERT(a_strobe_gap, clock, reset, rsp_valid_ff |=> !rsp_valid_ff,
               "results in back-to-back cycles")
   `SDF_ASSERT(a_kept_ovf, clock, reset, rsp_valid_ff |-> !(rsp_ff.kept && rsp_ff.overflow),
               "kept and overflow both set")
   `SDF_ASSERT(a_last_clear, clock, reset,
               (rsp_valid_ff && rsp_ff.end_of_array) |-> (count_ff == '0),
               "count not cleared after last beat")
   `SDF_ASSERT_ALWAYS(a_reset_idle, clock,
                      reset |=> (state_ff == BACK_IDLE && !rsp_valid_ff),
                      "back end active after reset")

endmodule

>>> tb/stream_dedup_first_occurrence_tb.sv
`timescale 1ns / 100ps

module stream_dedup_first_occurrence_tb;
   import sdf_pkg::*;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   stream_dedup_first_occurrence dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predictor state: the values kept so far in the current array.
   logic signed [VALUE_W-1:0] kept_values [TABLE_DEPTH];
   int unsigned               kept_total = 0;

   rsp_type     expected_results [$];
   rsp_type     oldest_expected;
   int unsigned error_count   = 0;
   int unsigned items_sent    = 0;
   bit          gaps_allowed  = 1'b1;
   bit          array_gaps    = 1'b1;

   function automatic rsp_type predict_dedup(req_type item);
      rsp_type r;
      bit      hit = 1'b0;
      for (int j = 0; j < kept_total; j++) begin
         if (kept_values[j] == item.value) begin
            hit = 1'b1;
            break;
         end
      end
      r.value_out = item.value;
      r.kept      = 1'b0;
      r.overflow  = 1'b0;
      if (!hit) begin
         if (kept_total < TABLE_DEPTH) begin
            kept_values[kept_total] = item.value;
            kept_total++;
            r.kept = 1'b1;
         end else begin
            r.overflow = 1'b1;
         end
      end
      r.unique_count = UCOUNT_W'(kept_total);
      r.end_of_array = item.is_last;
      if (item.is_last)
         kept_total = 0;
      return r;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // The receiver never stalls, so every strobe is an accepted beat.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            compare_field("value_out", oldest_expected.value_out, rsp_data.value_out);
            compare_field("kept", oldest_expected.kept, rsp_data.kept);
            compare_field("unique_count", oldest_expected.unique_count,
                          rsp_data.unique_count);
            compare_field("end_of_array", oldest_expected.end_of_array,
                          rsp_data.end_of_array);
            compare_field("overflow", oldest_expected.overflow, rsp_data.overflow);
         end
      end
   end

   task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic is_last);
      req_type item;
      item.value   = value;
      item.is_last = is_last;
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      expected_results.push_back(predict_dedup(item));
      items_sent++;
      if (gaps_allowed && array_gaps && $urandom_range(0, 3) == 0) begin
         // Junk on the data lines while start is low must be ignored.
         start    <= 1'b0;
         req_data <= {$urandom, 1'($urandom)};
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_array();
      int unsigned               pick = $urandom_range(0, 99);
      int unsigned               len;
      logic signed [VALUE_W-1:0] pool [$];
      logic signed [VALUE_W-1:0] sent_values [$];
      logic signed [VALUE_W-1:0] v;
      array_gaps = ($urandom_range(0, 9) >= 3);
      if (pick < 60) begin
         len = $urandom_range(1, 24);
         repeat ($urandom_range(1, 12))
            pool.push_back(($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) - 3 : $urandom);
      end else if (pick < 97) begin
         len = $urandom_range(1, 40);
      end else begin
         // Long array of mostly new values, about as long as the table is deep.
         len = $urandom_range(TABLE_DEPTH - 6, TABLE_DEPTH + 14);
      end
      for (int i = 0; i < len; i++) begin
         if (pick < 60) begin
            v = pool[$urandom_range(0, pool.size() - 1)];
         end else if (pick < 97) begin
            case ($urandom_range(0, 2))
               0: v = $urandom;
               1: v = $urandom_range(0, 6) - 3;
               default: v = (sent_values.size() != 0) ?
                            sent_values[$urandom_range(0, sent_values.size() - 1)] : $urandom;
            endcase
         end else begin
            v = ($urandom_range(0, 9) == 0 && sent_values.size() != 0) ?
                sent_values[$urandom_range(0, sent_values.size() - 1)] : $urandom;
         end
         sent_values.push_back(v);
         send_item(v, i == len - 1);
      end
   endtask

   task automatic test_directed_values();
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sd0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      send_item(32'sh5555_5555, 1'b0);
      send_item(32'shAAAA_AAAA, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sd7, 1'b0);
      send_item(32'sd7, 1'b0);
      send_item(32'sd7, 1'b1);
      send_item(32'sd0, 1'b1);
      send_item(32'sd0, 1'b1);
   endtask

   task automatic test_table_full();
      array_gaps = 1'b1;
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_item(i - TABLE_DEPTH / 2, 1'b0);
      send_item(32'sd1000, 1'b0);
      send_item(32'sd5, 1'b0);
      send_item(32'sd1000, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(-TABLE_DEPTH / 2, 1'b0);
      send_item(32'sd2000, 1'b1);
      // The table must start empty again after the last beat.
      send_item(32'sd1000, 1'b0);
      send_item(32'sd1000, 1'b1);
   endtask

   task automatic test_random_arrays();
      while (items_sent < 1230)
         send_random_array();
   endtask

   task automatic test_pause_for_drain();
      array_gaps = 1'b0;
      send_item(32'sd11, 1'b0);
      send_item(32'sd12, 1'b0);
      send_item(32'sd11, 1'b0);
      drain_results();
      send_item(32'sd12, 1'b0);
      send_item(32'sd13, 1'b1);
      drain_results();
      send_random_array();
   endtask

   task automatic test_back_to_back();
      gaps_allowed = 1'b0;
      while (items_sent < 1450)
         send_random_array();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_values();
      test_table_full();
      test_random_arrays();
      test_pause_for_drain();
      test_back_to_back();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("stream_dedup_first_occurrence regression: pass");
      end else begin
         $display("stream_dedup_first_occurrence regression: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("stream_dedup_first_occurrence regression: fail");
      $finish;
   end

endmodule
